@@ sv/assert_macros.svh @@
// assertion macros shared by the sequencer rtl
// no dependencies; included by the modules that check their own logic
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define TSS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sequencer assertion failed");

// next-cycle implication, checked outside reset
`define TSS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sequencer assertion failed");

`endif

@@ sv/tss_pkg.sv @@
// types and constants for the timed state table sequencer
// no dependencies; imported by tss_if, tss_dp, tss_ctrl and the top level of the block
`timescale 1ns / 1ps

package tss_pkg;

    localparam int KIND_W    = 3;
    localparam int STATE_W   = 5;
    localparam int EVENT_W   = 3;
    localparam int TIMEOUT_W = 32;

    localparam logic [KIND_W-1:0] KIND_APPEND = 3'd0;
    localparam logic [KIND_W-1:0] KIND_START  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_STOP   = 3'd2;
    localparam logic [KIND_W-1:0] KIND_TICK   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_SET    = 3'd4;

    localparam logic [EVENT_W-1:0] EV_NONE    = 3'd0;
    localparam logic [EVENT_W-1:0] EV_START   = 3'd1;
    localparam logic [EVENT_W-1:0] EV_STOP    = 3'd2;
    localparam logic [EVENT_W-1:0] EV_TIMEOUT = 3'd3;
    localparam logic [EVENT_W-1:0] EV_NEW     = 3'd4;

    localparam logic ST_OK   = 1'b0;
    localparam logic ST_FAIL = 1'b1;

    localparam logic [STATE_W-1:0] NO_STATE = 5'd31;

    typedef struct packed {
        logic capture;
        logic commit;
        logic second;
    } t_cmd;

    typedef struct packed {
        logic two_results;
    } t_stat;

endpackage

@@ sv/tss_if.sv @@
// request and result channel interfaces of the sequencer
// depends on tss_pkg for field widths
`timescale 1ns / 1ps

interface tss_in_if import tss_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [KIND_W-1:0]    kind;
    logic [TIMEOUT_W-1:0] entry_timeout;
    logic [STATE_W-1:0]   entry_fallback;
    logic [STATE_W-1:0]   entry_default_next;
    logic [STATE_W-1:0]   target_state;

    modport source (
        output valid, kind, entry_timeout, entry_fallback, entry_default_next, target_state,
        input  ready
    );
    modport sink (
        input  valid, kind, entry_timeout, entry_fallback, entry_default_next, target_state,
        output ready
    );
endinterface

interface tss_out_if import tss_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               status;
    logic [EVENT_W-1:0] event_res;
    logic [STATE_W-1:0] current_state;
    logic               last;

    modport source (
        output valid, status, event_res, current_state, last,
        input  ready
    );
    modport sink (
        input  valid, status, event_res, current_state, last,
        output ready
    );
endinterface

@@ sv/tss_dp.sv @@
// sequencer datapath: state tables, run counters, decision logic, result register
// depends on tss_pkg and assert_macros.svh; driven by tss_ctrl commands
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tss_dp import tss_pkg::*; #(
    parameter int MAX_STATES = 16,
    parameter int TIMER_BITS = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cmd                 i_cmd,
    output t_stat                o_stat,
    input  logic [KIND_W-1:0]    i_kind,
    input  logic [TIMEOUT_W-1:0] i_entry_timeout,
    input  logic [STATE_W-1:0]   i_entry_fallback,
    input  logic [STATE_W-1:0]   i_entry_default_next,
    input  logic [STATE_W-1:0]   i_target_state,
    output logic                 o_status,
    output logic [EVENT_W-1:0]   o_event_res,
    output logic [STATE_W-1:0]   o_current_state,
    output logic                 o_last
);

    localparam int IDX_W = (MAX_STATES > 1) ? $clog2(MAX_STATES) : 1;
    localparam logic [TIMER_BITS-1:0] NEVER = '1;
    localparam logic [STATE_W-1:0] MAX_ST = STATE_W'(MAX_STATES);

    logic [TIMER_BITS-1:0] mem_timeout  [MAX_STATES];
    logic [STATE_W-1:0]    mem_fallback [MAX_STATES];
    logic [STATE_W-1:0]    mem_defnext  [MAX_STATES];
    logic [TIMER_BITS-1:0] mem_cnt      [MAX_STATES];

    logic [TIMER_BITS-1:0] r_rd_timeout;
    logic [STATE_W-1:0]    r_rd_fallback;
    logic [STATE_W-1:0]    r_rd_defnext;
    logic [TIMER_BITS-1:0] r_rd_cnt;

    logic [KIND_W-1:0]     r_kind;
    logic [TIMER_BITS-1:0] r_timeout;
    logic [STATE_W-1:0]    r_fallback;
    logic [STATE_W-1:0]    r_defnext;
    logic [STATE_W-1:0]    r_target;

    logic [STATE_W-1:0]    r_state, n_state;
    logic [STATE_W-1:0]    r_count, n_count;
    logic                  r_run, n_run;

    logic                  r_o_status;
    logic [EVENT_W-1:0]    r_o_event;
    logic [STATE_W-1:0]    r_o_state;
    logic                  r_o_last;

    logic                  n_status;
    logic [EVENT_W-1:0]    n_event;
    logic                  n_two;
    logic                  w_valid;
    logic [TIMER_BITS-1:0] w_cnt;
    logic                  w_expire;
    logic                  w_move;
    logic                  w_app_we;
    logic                  w_cnt_we;
    logic [IDX_W-1:0]      w_cnt_addr;
    logic [TIMER_BITS-1:0] w_cnt_wd;

    always_comb begin
        w_valid  = (r_state < r_count);
        w_cnt    = r_rd_cnt + 1'b1;
        w_expire = (r_rd_timeout != NEVER) && (w_cnt >= r_rd_timeout);
        w_move   = (r_rd_fallback < r_count) && (r_rd_fallback != r_state);

        n_status   = ST_FAIL;
        n_event    = EV_NONE;
        n_two      = 1'b0;
        n_state    = r_state;
        n_count    = r_count;
        n_run      = r_run;
        w_app_we   = 1'b0;
        w_cnt_we   = 1'b0;
        w_cnt_addr = r_state[IDX_W-1:0];
        w_cnt_wd   = w_cnt;

        case (r_kind)
            KIND_APPEND: begin
                if (!r_run && (r_count < MAX_ST)) begin
                    n_status   = ST_OK;
                    w_app_we   = 1'b1;
                    w_cnt_we   = 1'b1;
                    w_cnt_addr = r_count[IDX_W-1:0];
                    w_cnt_wd   = '0;
                    n_count    = r_count + 1'b1;
                end
            end
            KIND_START: begin
                if (!r_run) begin
                    n_status = ST_OK;
                    n_event  = EV_START;
                    n_run    = 1'b1;
                end
            end
            KIND_STOP: begin
                if (r_run) begin
                    n_status = ST_OK;
                    n_event  = EV_STOP;
                    n_run    = 1'b0;
                end
            end
            KIND_TICK: begin
                if (r_run && w_valid) begin
                    n_status = ST_OK;
                    w_cnt_we = 1'b1;
                    if (w_expire) begin
                        n_event  = EV_TIMEOUT;
                        w_cnt_wd = '0;
                        if (w_move) begin
                            n_two   = 1'b1;
                            n_state = r_rd_fallback;
                        end
                    end
                end
            end
            KIND_SET: begin
                if (r_run && (r_count != '0)) begin
                    if (!w_valid) begin
                        if (r_target < r_count) begin
                            n_status = ST_OK;
                            n_event  = EV_NEW;
                            n_state  = r_target;
                        end
                    end else begin
                        n_status = ST_OK;
                        n_event  = EV_NEW;
                        n_state  = (r_target < r_count) ? r_target : r_rd_defnext;
                    end
                end
            end
            default: begin
                n_status = ST_FAIL;
            end
        endcase
    end

    assign o_stat.two_results = n_two;

    // table memories, read at the current state every cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && w_app_we) begin
            mem_timeout[r_count[IDX_W-1:0]]  <= r_timeout;
            mem_fallback[r_count[IDX_W-1:0]] <= r_fallback;
            mem_defnext[r_count[IDX_W-1:0]]  <= r_defnext;
        end
        r_rd_timeout  <= mem_timeout[r_state[IDX_W-1:0]];
        r_rd_fallback <= mem_fallback[r_state[IDX_W-1:0]];
        r_rd_defnext  <= mem_defnext[r_state[IDX_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && w_cnt_we) begin
            mem_cnt[w_cnt_addr] <= w_cnt_wd;
        end
        r_rd_cnt <= mem_cnt[r_state[IDX_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_kind     <= i_kind;
            r_timeout  <= i_entry_timeout[TIMER_BITS-1:0];
            r_fallback <= i_entry_fallback;
            r_defnext  <= i_entry_default_next;
            r_target   <= i_target_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= NO_STATE;
            r_count <= '0;
            r_run   <= 1'b0;
        end else if (i_cmd.commit) begin
            r_state <= n_state;
            r_count <= n_count;
            r_run   <= n_run;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_o_status <= n_status;
            r_o_event  <= n_event;
            r_o_state  <= n_two ? r_state : n_state;
            r_o_last   <= !n_two;
        end else if (i_cmd.second) begin
            r_o_status <= ST_OK;
            r_o_event  <= EV_NEW;
            r_o_state  <= r_state;
            r_o_last   <= 1'b1;
        end
    end

    assign o_status        = r_o_status;
    assign o_event_res     = r_o_event;
    assign o_current_state = r_o_state;
    assign o_last          = r_o_last;

    `TSS_ASSERT_IMP(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= MAX_ST)
    `TSS_ASSERT_IMP(a_move_in_range, i_clk, i_rst_n, i_cmd.commit && n_two, n_state < r_count)

endmodule

@@ sv/tss_ctrl.sv @@
// sequencer controller: request sequencing and result handshake
// depends on tss_pkg and assert_macros.svh; commands tss_dp
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tss_ctrl import tss_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    output logic  o_out_valid,
    input  logic  i_out_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_EXEC   = 2'd1;
    localparam logic [1:0] S_SECOND = 2'd2;

    logic [1:0] r_fsm, n_fsm;
    logic       r_o_valid, n_o_valid;
    logic       w_out_free;

    assign w_out_free = !r_o_valid || i_out_ready;
    assign o_in_ready = (r_fsm == S_IDLE);

    always_comb begin
        o_cmd.capture = i_in_valid && (r_fsm == S_IDLE);
        o_cmd.commit  = (r_fsm == S_EXEC) && w_out_free;
        o_cmd.second  = (r_fsm == S_SECOND) && w_out_free;

        n_fsm = r_fsm;
        case (r_fsm)
            S_IDLE: begin
                if (o_cmd.capture) begin
                    n_fsm = S_EXEC;
                end
            end
            S_EXEC: begin
                if (o_cmd.commit) begin
                    n_fsm = i_stat.two_results ? S_SECOND : S_IDLE;
                end
            end
            S_SECOND: begin
                if (o_cmd.second) begin
                    n_fsm = S_IDLE;
                end
            end
            default: begin
                n_fsm = S_IDLE;
            end
        endcase

        if (o_cmd.commit || o_cmd.second) begin
            n_o_valid = 1'b1;
        end else if (i_out_ready) begin
            n_o_valid = 1'b0;
        end else begin
            n_o_valid = r_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fsm     <= S_IDLE;
            r_o_valid <= 1'b0;
        end else begin
            r_fsm     <= n_fsm;
            r_o_valid <= n_o_valid;
        end
    end

    assign o_out_valid = r_o_valid;

    `TSS_ASSERT_NXT(a_capture_exec, i_clk, i_rst_n, o_cmd.capture, r_fsm == S_EXEC)
    `TSS_ASSERT_NXT(a_two_second, i_clk, i_rst_n, o_cmd.commit && i_stat.two_results, (r_fsm == S_SECOND) && r_o_valid)

endmodule

@@ sv/timed_state_table_sequencer_core.sv @@
// channel    dir  handshake     payload
// i_req      in   valid/ready   kind, entry_timeout, entry_fallback, entry_default_next, target_state
// o_rsp      out  valid/ready   status, event_res, current_state, last
//
// one request is worked at a time: accept, then read the state tables and decide; a
// timeout that moves state gives a second result, sent after the first is taken
// a tick reads and writes back the run counter of the current state; an append writes one table entry
// reset is synchronous, active low; tables hold nothing until entries are appended
// a stalled result holds in the output register; the next request is taken meanwhile
//
// top level of the timed state table sequencer; depends on tss_pkg, tss_if, tss_ctrl, tss_dp
`timescale 1ns / 1ps

module timed_state_table_sequencer_core import tss_pkg::*; #(
    parameter int MAX_STATES = 16,
    parameter int TIMER_BITS = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    tss_in_if.sink    i_req,
    tss_out_if.source o_rsp
);

    t_cmd  w_cmd;
    t_stat w_stat;
    logic  w_in_ready;
    logic  w_out_valid;

    tss_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (w_in_ready),
        .o_out_valid (w_out_valid),
        .i_out_ready (o_rsp.ready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    tss_dp #(
        .MAX_STATES (MAX_STATES),
        .TIMER_BITS (TIMER_BITS)
    ) u_dp (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cmd                (w_cmd),
        .o_stat               (w_stat),
        .i_kind               (i_req.kind),
        .i_entry_timeout      (i_req.entry_timeout),
        .i_entry_fallback     (i_req.entry_fallback),
        .i_entry_default_next (i_req.entry_default_next),
        .i_target_state       (i_req.target_state),
        .o_status             (o_rsp.status),
        .o_event_res          (o_rsp.event_res),
        .o_current_state      (o_rsp.current_state),
        .o_last               (o_rsp.last)
    );

    assign i_req.ready = w_in_ready;
    assign o_rsp.valid = w_out_valid;

endmodule
